### rtl/core/hpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpa_pkg
// Shared constants and types of the hole placement allocator.
// ----------------------------------------------------------------------------
package hpa_pkg;

	localparam int HOLES     = 16;
	localparam int ADDR_BITS = 16;
	localparam int SIZE_W    = 16;
	localparam int IDX_W     = (HOLES > 1) ? $clog2(HOLES) : 1;
	localparam int CNT_W     = $clog2(HOLES + 1);

	localparam logic [1:0] MODE_FIRST = 2'd0;
	localparam logic [1:0] MODE_BEST  = 2'd1;
	localparam logic [1:0] MODE_WORST = 2'd2;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_ALLOC = 1'b1;

	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_COUNT = 2'd1;

	typedef struct packed {
		logic        command;
		logic [3:0]  hole_index;
		logic [15:0] hole_base;
		logic [15:0] hole_size;
		logic [15:0] request_size;
		logic        last_request;
	} req_t;

	typedef struct packed {
		logic        granted;
		logic [15:0] grant_address;
		logic [3:0]  chosen_hole;
		logic        batch_done;
	} rsp_t;

	typedef struct packed {
		logic                 valid;
		logic [SIZE_W-1:0]    size;
		logic [IDX_W-1:0]     idx;
		logic [ADDR_BITS-1:0] addr;
	} cand_t;

	typedef struct packed {
		logic load;
		logic take;
		logic in_use;
	} cell_ctl_t;

endpackage
`default_nettype wire

### rtl/core/hpa_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpa_if
// Valid/ready channels of the allocator: request, response and config write.
// ----------------------------------------------------------------------------
interface hpa_req_if;
	logic          valid;
	logic          ready;
	hpa_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface hpa_rsp_if;
	logic          valid;
	logic          ready;
	hpa_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface hpa_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] addr;
	logic [4:0] data;
	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/hole_placement_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hole_placement_allocator_unit
// First, best or worst fit allocator over a chain of hole cells.
//
// Channels: req (sink) carries load and allocate commands, rsp (source) one
// result per allocate, cfg (sink) writes placement_mode (index 0) and
// hole_count (index 1); cfg is always ready, other indexes are dropped.
// A load gives no result. An allocate starts a search: the best candidate
// ripples one cell per cycle down the chain of HOLES cells; the result is
// registered when the count of search steps reaches HOLES, and the unit
// returns to idle and takes the next request once that result is written.
// The chosen hole shrinks and its address advances when the result is
// written to the output register. A result waiting in the output register
// does not block req: loads and the next allocate are still taken. If the
// receiver stalls, that next search holds its finished result, with req
// not ready, until the output register is free.
// Reset clears all holes to size and address zero, both registers to zero
// and drops any pending result.
// ----------------------------------------------------------------------------
module hole_placement_allocator_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	hpa_req_if.sink     req,
	hpa_rsp_if.source   rsp,
	hpa_cfg_if.sink     cfg
);

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_SEARCH = 1'b1;

	logic                            state_q;
	logic [hpa_pkg::CNT_W-1:0]       cnt_q;
	logic [1:0]                      mode_q;
	logic [4:0]                      hole_count_q;
	logic [hpa_pkg::SIZE_W-1:0]      need_q;
	logic                            last_q;
	logic                            rsp_valid_q;
	hpa_pkg::rsp_t                   rsp_data_q;
	logic                            req_xfer;
	logic                            finish;
	hpa_pkg::cand_t                  cand [0:hpa_pkg::HOLES];
	hpa_pkg::cand_t                  tail;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign req_xfer  = req.valid && req.ready;
	assign tail      = cand[hpa_pkg::HOLES];
	assign finish    = (state_q == ST_SEARCH) &&
	                   (cnt_q == hpa_pkg::CNT_W'(hpa_pkg::HOLES)) &&
	                   (!rsp_valid_q || rsp.ready);

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= hpa_pkg::MODE_FIRST;
			hole_count_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.addr == hpa_pkg::REG_MODE) begin
				mode_q <= cfg.data[1:0];
			end else if (cfg.addr == hpa_pkg::REG_COUNT) begin
				hole_count_q <= cfg.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_xfer && req.data.command == hpa_pkg::CMD_ALLOC) begin
						state_q <= ST_SEARCH;
						cnt_q   <= '0;
					end
				end
				ST_SEARCH: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end else if (cnt_q != hpa_pkg::CNT_W'(hpa_pkg::HOLES)) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer && req.data.command == hpa_pkg::CMD_ALLOC) begin
			need_q <= req.data.request_size;
			last_q <= req.data.last_request;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_data_q.granted       <= tail.valid;
			rsp_data_q.grant_address <= tail.valid ? 16'(tail.addr) : 16'd0;
			rsp_data_q.chosen_hole   <= tail.valid ? 4'(tail.idx) : 4'd0;
			rsp_data_q.batch_done    <= last_q;
		end
	end

	assign cand[0] = '0;

	for (genvar i = 0; i < hpa_pkg::HOLES; i++) begin : g_cell
		hpa_pkg::cell_ctl_t ctl;

		assign ctl.load   = req_xfer && (req.data.command == hpa_pkg::CMD_LOAD) &&
		                    (32'(req.data.hole_index) == i);
		assign ctl.take   = finish && tail.valid && (tail.idx == hpa_pkg::IDX_W'(i));
		assign ctl.in_use = 32'(hole_count_q) > i;

		hpa_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.my_idx   (hpa_pkg::IDX_W'(i)),
			.mode     (mode_q),
			.need     (need_q),
			.load_base(hpa_pkg::ADDR_BITS'(req.data.hole_base)),
			.load_size(req.data.hole_size),
			.cand_in  (cand[i]),
			.cand_out (cand[i+1])
		);
	end

endmodule
`default_nettype wire

### rtl/core/hpa_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpa_cell
// One hole entry; merges its own fit into the candidate passed down the chain.
// ----------------------------------------------------------------------------
module hpa_cell (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire hpa_pkg::cell_ctl_t            ctl,
	input  wire logic [hpa_pkg::IDX_W-1:0]     my_idx,
	input  wire logic [1:0]                    mode,
	input  wire logic [hpa_pkg::SIZE_W-1:0]    need,
	input  wire logic [hpa_pkg::ADDR_BITS-1:0] load_base,
	input  wire logic [hpa_pkg::SIZE_W-1:0]    load_size,
	input  wire hpa_pkg::cand_t                cand_in,
	output hpa_pkg::cand_t                     cand_out
);

	logic [hpa_pkg::SIZE_W-1:0]    size_q;
	logic [hpa_pkg::ADDR_BITS-1:0] addr_q;
	hpa_pkg::cand_t                cand_q;
	logic                          fits;
	logic                          wins;

	assign fits = ctl.in_use && (size_q >= need);

	always_comb begin
		wins = 1'b0;
		if (fits) begin
			priority if (!cand_in.valid) begin
				wins = 1'b1;
			end else if (mode == hpa_pkg::MODE_BEST) begin
				wins = size_q < cand_in.size;
			end else if (mode == hpa_pkg::MODE_WORST) begin
				wins = size_q > cand_in.size;
			end else begin
				wins = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
			addr_q <= '0;
		end else if (ctl.load) begin
			size_q <= load_size;
			addr_q <= load_base;
		end else if (ctl.take) begin
			size_q <= size_q - need;
			addr_q <= addr_q + hpa_pkg::ADDR_BITS'(need);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else if (wins) begin
			cand_q <= {1'b1, size_q, my_idx, addr_q};
		end else begin
			cand_q <= cand_in;
		end
	end

	assign cand_out = cand_q;

endmodule
`default_nettype wire

### rtl/core/hpa_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module hpa_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	input  wire logic        req_ready,
	input  wire logic        req_command,
	input  wire logic        rsp_valid,
	input  wire logic        rsp_ready,
	input  wire logic        rsp_granted,
	input  wire logic [15:0] rsp_address,
	input  wire logic [3:0]  rsp_hole,
	input  wire logic        cfg_ready
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_address) &&
		$stable(rsp_granted) && $stable(rsp_hole))
		else $error("stalled response changed");

	a_deny_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_granted |-> rsp_address == 16'd0 && rsp_hole == 4'd0)
		else $error("denied response carries nonzero fields");

	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_command |=> !req_ready)
		else $error("request taken during search");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule

bind hole_placement_allocator_unit hpa_checker u_hpa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_command(req.data.command),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_granted(rsp.data.granted),
	.rsp_address(rsp.data.grant_address),
	.rsp_hole   (rsp.data.chosen_hole),
	.cfg_ready  (cfg.ready)
);
`default_nettype wire
